@@ hw/rtl/sha_pkg.sv @@
// SHA-256 shared types, constants and the rotate-right helper.
// No dependencies.
`default_nettype none
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_PAD,
        ST_OUT
    } t_state;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/sha_block_ram.sv @@
// 16 x 32-bit block/schedule memory, one write and one registered read port.
// No dependencies.
`default_nettype none
module sha_block_ram (
    input  wire logic        i_clk,
    input  wire logic        i_we,
    input  wire logic [3:0]  i_waddr,
    input  wire logic [31:0] i_wdata,
    input  wire logic [3:0]  i_raddr,
    output logic      [31:0] o_rdata
);
    logic [31:0] mem [16];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/sha_core.sv @@
// SHA-256 compression: schedule window in registers, one round per cycle.
// Reads message words from sha_block_ram; uses sha_pkg.
`default_nettype none
module sha_core
    import sha_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_init,
    input  wire logic [31:0] i_mem_word,
    output logic      [3:0]  o_mem_addr,
    output logic             o_busy,
    output logic      [255:0] o_chain
);
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_fold;
    logic [31:0] w_cur, s0, s1, t1, t2, b1, b0, ch, mj;

    // Word i arrives in the cycle after its address (registered RAM read); r_cnt counts prefetch ahead.
    assign o_mem_addr = r_cnt[3:0];
    assign o_busy = r_busy | r_fold;

    always_comb begin
        s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_cur = (r_cnt <= 7'd16) ? i_mem_word : (r_w[0] + s0 + r_w[9] + s1);
        b1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        b0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1 = r_v[7] + b1 + ch + ROUND_K[6'(r_cnt - 7'd1)] + w_cur;
        t2 = b0 + mj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fold <= 1'b0;
            r_cnt  <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= INIT_HASH[i];
        end else if (i_init) begin
            for (int i = 0; i < 8; i++) r_h[i] <= INIT_HASH[i];
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd1;
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (r_busy) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
            r_w[15] <= w_cur;
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            // park the address on word 0 for the next block
            if (r_cnt == 7'd64) begin
                r_busy <= 1'b0;
                r_fold <= 1'b1;
                r_cnt  <= '0;
            end else begin
                r_cnt <= r_cnt + 7'd1;
            end
        end else if (r_fold) begin
            // add working words back into the chain
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            r_fold <= 1'b0;
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) o_chain[255 - 32*i -: 32] = r_h[i];
    end
endmodule
`default_nettype wire

@@ hw/rtl/sha256_byte_stream_hash.sv @@
// Top level: byte packing, padding sequencer and digest output.
// Uses sha_pkg, sha_block_ram and sha_core.
// A byte transaction is taken only while idle; the 64th byte of a block stalls
// the input through the load, 64 rounds, chain fold and return to idle. A last
// transaction adds padding at one byte a cycle up to the end of the block, each
// full block compressed the same way, with a second block when the 0x80 byte
// lands at byte 56 or later; then four 64-bit digest chunks follow, big-endian,
// word 0 first, one a cycle while not stalled, and the next message begins.
`default_nettype none
module sha256_byte_stream_hash
    import sha_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_present,
    input  wire logic        i_is_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [63:0] o_digest_chunk,
    output logic      [1:0]  o_chunk_index,
    output logic             o_last_chunk
);
    t_state r_state, n_state;
    logic [5:0]  r_fill;
    logic [63:0] r_len;
    logic [63:0] r_bits;
    logic [23:0] r_acc;
    logic        r_padding;
    logic        r_pad80;
    logic        r_spill;
    logic        r_final;
    logic [1:0]  r_chunk;
    logic        core_busy, core_start, core_init;
    logic [3:0]  core_addr;
    logic [31:0] mem_rd;
    logic [255:0] chain;
    logic        push;
    logic [7:0]  push_byte;
    logic        accept;
    logic        in_len;

    sha_block_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (push && (r_fill[1:0] == 2'd3)),
        .i_waddr(r_fill[5:2]),
        .i_wdata({r_acc, push_byte}),
        .i_raddr(core_addr),
        .o_rdata(mem_rd)
    );

    sha_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (core_start),
        .i_init    (core_init),
        .i_mem_word(mem_rd),
        .o_mem_addr(core_addr),
        .o_busy    (core_busy),
        .o_chain   (chain)
    );

    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_OUT);
    assign o_digest_chunk = chain[8'd255 - {r_chunk, 6'd0} -: 64];
    assign o_chunk_index = r_chunk;
    assign o_last_chunk = (r_chunk == 2'd3);
    // length bytes fill 56..63 of the block that does not hold a late 0x80
    assign in_len = !r_pad80 && !r_spill && (r_fill >= LEN_START);

    always_comb begin
        n_state = r_state;
        push = 1'b0;
        push_byte = i_data_byte;
        core_start = 1'b0;
        core_init = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    push = i_byte_present;
                    if (i_byte_present && r_fill == 6'd63) n_state = ST_LOAD;
                    else if (i_is_last) n_state = ST_PAD;
                end
            end
            ST_LOAD: begin
                core_start = 1'b1;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                if (!core_busy) begin
                    if (r_final) n_state = ST_OUT;
                    else if (r_padding) n_state = ST_PAD;
                    else n_state = ST_IDLE;
                end
            end
            ST_PAD: begin
                push = 1'b1;
                if (r_pad80) push_byte = PAD_BYTE;
                else if (in_len) push_byte = r_bits[63:56];
                else push_byte = 8'h00;
                if (r_fill == 6'd63) n_state = ST_LOAD;
            end
            ST_OUT: begin
                if (!i_stall && r_chunk == 2'd3) begin
                    core_init = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_len     <= '0;
            r_bits    <= '0;
            r_padding <= 1'b0;
            r_pad80   <= 1'b0;
            r_spill   <= 1'b0;
            r_final   <= 1'b0;
            r_chunk   <= '0;
        end else begin
            r_state <= n_state;
            if (push) begin
                r_fill <= r_fill + 6'd1;
                r_acc  <= {r_acc[15:0], push_byte};
            end
            if (r_state == ST_IDLE && accept) begin
                if (i_byte_present) r_len <= r_len + 64'd1;
                if (i_is_last) begin
                    r_padding <= 1'b1;
                    r_pad80   <= 1'b1;
                    r_bits    <= (r_len + {63'd0, i_byte_present}) << 3;
                end
            end
            if (r_state == ST_PAD) begin
                if (r_pad80) r_pad80 <= 1'b0;
                if (in_len) r_bits <= r_bits << 8;
                if (r_fill == 6'd63) begin
                    r_spill <= 1'b0;
                    if (in_len) r_final <= 1'b1;
                end else if (r_pad80 && r_fill >= LEN_START) begin
                    // 0x80 leaves no room for the length: zero out this block
                    r_spill <= 1'b1;
                end
            end
            if (r_state == ST_OUT && !i_stall) begin
                r_chunk <= r_chunk + 2'd1;
                if (r_chunk == 2'd3) begin
                    r_len     <= '0;
                    r_padding <= 1'b0;
                    r_final   <= 1'b0;
                end
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !core_busy) else $error("digest shown during compression");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_start |-> r_fill == 6'd0) else $error("compression started mid-block");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> r_state == ST_IDLE) else $error("transaction taken while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_digest_chunk)
                                  && $stable(o_chunk_index)))
        else $error("stalled digest chunk changed");
endmodule
`default_nettype wire
